FILE: src/psp_pkg.sv
// psp_pkg: shared types, constants and helpers for the psi section packetizer
// no dependencies; used by psp_front, psp_queue, psp_back and the top level
package psp_pkg;

  localparam int COUNTER_SLOTS_DEF = 2;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [7:0]  PACKET_BYTES  = 8'd188;
  localparam logic [7:0]  SYNC_BYTE     = 8'h47;
  localparam logic [3:0]  ADAPT_PAYLOAD = 4'h1;
  localparam logic [7:0]  STUFF_BYTE    = 8'hff;
  localparam logic [7:0]  POINTER_BYTE  = 8'h00;
  localparam logic [31:0] STUFF_WORD    = 32'hffff_ffff;

  // one command per input byte that yields at least one word
  typedef struct packed {
    logic        hdr_v;
    logic [31:0] hdr_word;
    logic        dat_v;
    logic [31:0] dat_word;
    logic        dat_pend;
    logic        dat_send;
    logic        stf_v;
    logic [31:0] stf_word;
    logic [5:0]  stf_cnt;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_HDR,
    BK_DAT,
    BK_STF
  } bk_state_t;

  function automatic bk_state_t after_dat(cmd_t c);
    bk_state_t s;
    s = c.stf_v ? BK_STF : BK_IDLE;
    return s;
  endfunction

  function automatic bk_state_t after_hdr(cmd_t c);
    bk_state_t s;
    s = c.dat_v ? BK_DAT : after_dat(c);
    return s;
  endfunction

  function automatic bk_state_t first_phase(cmd_t c);
    bk_state_t s;
    s = c.hdr_v ? BK_HDR : after_hdr(c);
    return s;
  endfunction

endpackage

FILE: src/psp_front.sv
// psp_front: accepts section bytes, tracks section and packet position,
// and turns each byte into a word command; depends on psp_pkg
module psp_front #(
  parameter int COUNTER_SLOTS = psp_pkg::COUNTER_SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_section_byte,
  input  logic [12:0]    in_stream_pid,
  input  logic           in_counter_slot,
  output logic           q_push,
  output psp_pkg::cmd_t  q_data,
  input  logic           q_full
);

  localparam int CW = (COUNTER_SLOTS > 1) ? $clog2(COUNTER_SLOTS) : 1;

  logic [3:0]  cc_r [COUNTER_SLOTS];
  logic        in_section_r, in_section_nxt;
  logic [12:0] bs_r, bs_nxt;
  logic [12:0] total_r, total_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [23:0] pend_r, pend_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [12:0] pid_r, pid_nxt;
  logic        slot_r, slot_nxt;

  logic          accept, start, hdr_v, fin, slot;
  logic [12:0]   pid, bs, bs1, total, total_n;
  logic [CW-1:0] sidx;
  logic [3:0]    cc;
  logic [7:0]    p, p1, p2, aligned;
  logic [1:0]    c, c2;
  logic [23:0]   q, q2;
  psp_pkg::cmd_t cmd;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    start = !in_section_r;
    pid   = start ? in_stream_pid : pid_r;
    slot  = start ? in_counter_slot : slot_r;
    sidx  = (COUNTER_SLOTS == 1) ? '0 : CW'(slot);
    cc    = cc_r[sidx];
    hdr_v = start || (pos_r == 8'd0);

    p = pos_r;
    c = cnt_r;
    q = pend_r;
    if (hdr_v) begin
      p = 8'd4;
      c = 2'd0;
      q = 24'd0;
    end
    // first packet carries the pointer byte ahead of the payload
    if (start) begin
      p = 8'd5;
      c = 2'd1;
      q = {16'd0, psp_pkg::POINTER_BYTE};
    end

    bs      = start ? 13'd0 : bs_r;
    total   = start ? 13'd0 : total_r;
    total_n = total;
    if (bs == 13'd1) begin
      total_n = {1'b0, in_section_byte[3:0], 8'h00};
    end else if (bs == 13'd2) begin
      total_n = (total | {5'd0, in_section_byte}) + 13'd3;
    end
    bs1 = bs + 13'd1;
    fin = (bs1 >= 13'd3) && (bs1 >= total_n);

    p1           = p + 8'd1;
    cmd          = '0;
    cmd.hdr_v    = hdr_v;
    cmd.hdr_word = {psp_pkg::SYNC_BYTE, 1'b0, start, 1'b0, pid, psp_pkg::ADAPT_PAYLOAD, cc};
    cmd.dat_v    = (c == 2'd3);
    cmd.dat_word = {q, in_section_byte};
    cmd.dat_pend = cmd.dat_v && (p1 == psp_pkg::PACKET_BYTES);
    cmd.dat_send = fin && cmd.dat_pend;

    if (c == 2'd3) begin
      c2 = 2'd0;
      q2 = 24'd0;
      p2 = cmd.dat_pend ? 8'd0 : p1;
    end else begin
      c2 = c + 2'd1;
      q2 = {q[15:0], in_section_byte};
      p2 = p1;
    end

    // last byte short of the packet end: pad with stuffing
    cmd.stf_v = fin && (p1 < psp_pkg::PACKET_BYTES);
    case (c2)
      2'd0:    cmd.stf_word = psp_pkg::STUFF_WORD;
      2'd1:    cmd.stf_word = {q2[7:0], {3{psp_pkg::STUFF_BYTE}}};
      2'd2:    cmd.stf_word = {q2[15:0], {2{psp_pkg::STUFF_BYTE}}};
      default: cmd.stf_word = {q2, psp_pkg::STUFF_BYTE};
    endcase
    aligned     = p2 - {6'd0, c2};
    cmd.stf_cnt = 6'((psp_pkg::PACKET_BYTES - aligned) >> 2);

    q_data = cmd;
    q_push = accept && (cmd.hdr_v || cmd.dat_v || cmd.stf_v);

    in_section_nxt = in_section_r;
    bs_nxt         = bs_r;
    total_nxt      = total_r;
    pos_nxt        = pos_r;
    pend_nxt       = pend_r;
    cnt_nxt        = cnt_r;
    pid_nxt        = pid_r;
    slot_nxt       = slot_r;
    if (accept) begin
      pid_nxt   = pid;
      slot_nxt  = slot;
      total_nxt = total_n;
      if (fin) begin
        in_section_nxt = 1'b0;
        bs_nxt         = 13'd0;
        pos_nxt        = 8'd0;
        pend_nxt       = 24'd0;
        cnt_nxt        = 2'd0;
      end else begin
        in_section_nxt = 1'b1;
        bs_nxt         = bs1;
        pos_nxt        = p2;
        pend_nxt       = q2;
        cnt_nxt        = c2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < COUNTER_SLOTS; i++) begin
        cc_r[i] <= 4'd0;
      end
      in_section_r <= 1'b0;
      bs_r         <= 13'd0;
      total_r      <= 13'd0;
      pos_r        <= 8'd0;
      pend_r       <= 24'd0;
      cnt_r        <= 2'd0;
      pid_r        <= 13'd0;
      slot_r       <= 1'b0;
    end else begin
      if (accept && hdr_v) begin
        cc_r[sidx] <= cc + 4'd1;
      end
      in_section_r <= in_section_nxt;
      bs_r         <= bs_nxt;
      total_r      <= total_nxt;
      pos_r        <= pos_nxt;
      pend_r       <= pend_nxt;
      cnt_r        <= cnt_nxt;
      pid_r        <= pid_nxt;
      slot_r       <= slot_nxt;
    end
  end

endmodule

FILE: src/psp_queue.sv
// psp_queue: short command queue between front and back
// depends on psp_pkg for the command type and depth
module psp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  psp_pkg::cmd_t  push_data,
  output logic           full,
  input  logic           pop,
  output psp_pkg::cmd_t  head,
  output logic           empty
);

  localparam int DEPTH = psp_pkg::QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  psp_pkg::cmd_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + (AW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: src/psp_back.sv
// psp_back: expands word commands into output beats through a registered
// output stage; depends on psp_pkg
module psp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  psp_pkg::cmd_t  q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    out_ts_word,
  output logic           out_packet_end,
  output logic           out_section_end,
  output logic           out_last_in_burst
);

  psp_pkg::bk_state_t state_r, state_nxt;
  psp_pkg::cmd_t      cur_r, cur_nxt;
  logic [5:0]         stf_cnt_r, stf_cnt_nxt;
  logic               stf_first_r, stf_first_nxt;
  logic               valid_r, valid_nxt;
  logic [31:0]        word_r, word_nxt;
  logic               pend_r, pend_nxt;
  logic               send_r, send_nxt;
  logic               last_r, last_nxt;
  logic               out_free, emit, stf_last;
  logic [31:0]        e_word;
  logic               e_pend, e_send;

  assign out_free = !valid_r || out_ready;
  assign stf_last = (stf_cnt_r == 6'd1);

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    stf_cnt_nxt   = stf_cnt_r;
    stf_first_nxt = stf_first_r;
    q_pop         = 1'b0;
    emit          = 1'b0;
    e_word        = cur_r.hdr_word;
    e_pend        = 1'b0;
    e_send        = 1'b0;

    case (state_r)
      psp_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop         = 1'b1;
          cur_nxt       = q_head;
          stf_cnt_nxt   = q_head.stf_cnt;
          stf_first_nxt = 1'b1;
          state_nxt     = psp_pkg::first_phase(q_head);
        end
      end
      psp_pkg::BK_HDR: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = psp_pkg::after_hdr(cur_r);
        end
      end
      psp_pkg::BK_DAT: begin
        if (out_free) begin
          emit      = 1'b1;
          e_word    = cur_r.dat_word;
          e_pend    = cur_r.dat_pend;
          e_send    = cur_r.dat_send;
          state_nxt = psp_pkg::after_dat(cur_r);
        end
      end
      psp_pkg::BK_STF: begin
        if (out_free) begin
          emit          = 1'b1;
          e_word        = stf_first_r ? cur_r.stf_word : psp_pkg::STUFF_WORD;
          e_pend        = stf_last;
          e_send        = stf_last;
          stf_first_nxt = 1'b0;
          stf_cnt_nxt   = stf_cnt_r - 6'd1;
          state_nxt     = stf_last ? psp_pkg::BK_IDLE : psp_pkg::BK_STF;
        end
      end
      default: begin
        state_nxt = psp_pkg::BK_IDLE;
      end
    endcase

    valid_nxt = valid_r && !out_ready;
    word_nxt  = word_r;
    pend_nxt  = pend_r;
    send_nxt  = send_r;
    last_nxt  = last_r;
    if (emit) begin
      valid_nxt = 1'b1;
      word_nxt  = e_word;
      pend_nxt  = e_pend;
      send_nxt  = e_send;
      last_nxt  = (state_nxt == psp_pkg::BK_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psp_pkg::BK_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    stf_cnt_r   <= stf_cnt_nxt;
    stf_first_r <= stf_first_nxt;
    word_r      <= word_nxt;
    pend_r      <= pend_nxt;
    send_r      <= send_nxt;
    last_r      <= last_nxt;
  end

  assign out_valid         = valid_r;
  assign out_ts_word       = word_r;
  assign out_packet_end    = pend_r;
  assign out_section_end   = send_r;
  assign out_last_in_burst = last_r;

endmodule

FILE: src/psi_section_to_ts_packetizer_top.sv
// Packs PSI section bytes into 188-byte transport packets, sent as 32-bit words with the
// earliest byte in the top bits. A byte is taken whenever the two-entry command queue
// has room; the back end picks up a command when idle and then sends one word per cycle
// while the receiver does not stall. The last byte of a section yields up to 47 words
// (header, data and stuffing to the packet end), one per cycle unless the receiver
// stalls. Continuity counters start at zero after reset and are kept per slot.
// top level: psp_front, psp_queue and psp_back; depends on psp_pkg
module psi_section_to_ts_packetizer_top #(
  parameter int COUNTER_SLOTS = psp_pkg::COUNTER_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_section_byte,
  input  logic [12:0] in_stream_pid,
  input  logic        in_counter_slot,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_ts_word,
  output logic        out_packet_end,
  output logic        out_section_end,
  output logic        out_last_in_burst
);

  psp_pkg::cmd_t push_data, head;
  logic          push, full, pop, empty;

  psp_front #(
    .COUNTER_SLOTS (COUNTER_SLOTS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_section_byte (in_section_byte),
    .in_stream_pid   (in_stream_pid),
    .in_counter_slot (in_counter_slot),
    .q_push          (push),
    .q_data          (push_data),
    .q_full          (full)
  );

  psp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  psp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (empty),
    .q_head            (head),
    .q_pop             (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_ts_word       (out_ts_word),
    .out_packet_end    (out_packet_end),
    .out_section_end   (out_section_end),
    .out_last_in_burst (out_last_in_burst)
  );

endmodule

FILE: src/psp_checker.sv
// psp_checker: port-level checks on the packetizer result channel
// bound to psi_section_to_ts_packetizer_top; no package dependency
module psp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_ts_word,
  input logic        out_packet_end,
  input logic        out_section_end,
  input logic        out_last_in_burst
);

  // a stalled beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ts_word) &&
      $stable(out_packet_end) && $stable(out_section_end) && $stable(out_last_in_burst))
    else $error("stalled output beat changed");

  // the section always closes on a packet boundary and ends the burst
  a_sec_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_section_end |-> out_packet_end && out_last_in_burst)
    else $error("section end off a packet boundary or mid burst");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind psi_section_to_ts_packetizer_top psp_checker u_psp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_ts_word       (out_ts_word),
  .out_packet_end    (out_packet_end),
  .out_section_end   (out_section_end),
  .out_last_in_burst (out_last_in_burst)
);

FILE: test/psp_stream_checker.sv
`timescale 1ns / 1ps
// psp_stream_checker: watches both channels of the section packetizer, predicts the
// transport words from every accepted section byte and compares them in order
// depends on psp_pkg for the packet constants
module psp_stream_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_section_byte,
  input  logic [12:0] in_stream_pid,
  input  logic        in_counter_slot,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_ts_word,
  input  logic        out_packet_end,
  input  logic        out_section_end,
  input  logic        out_last_in_burst,
  output int          mismatches,
  output int          words_pending,
  output int          words_checked,
  output int          sections_done
);

  localparam int CC_SLOTS = psp_pkg::COUNTER_SLOTS_DEF;

  typedef struct packed {
    logic [31:0] word;
    logic        pkt_end;
    logic        sec_end;
    logic        burst_last;
  } ts_beat_t;

  ts_beat_t    expected_words[$];
  ts_beat_t    head;

  logic [3:0]  cont_cnt [CC_SLOTS];
  logic        in_sec;
  logic [12:0] seen;
  logic [12:0] sec_len;
  logic [7:0]  pkt_pos;
  logic [23:0] gather;
  logic [1:0]  gather_cnt;
  logic [12:0] sec_pid;
  logic        sec_slot;

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch in %s: got %h, expected %h (word %0d)",
             $time, field, got, want, words_checked);
    mismatches++;
  endtask

  task automatic emit_expected_word(input logic [31:0] word, input logic pend,
                                    input logic send);
    ts_beat_t beat;
    beat.word       = word;
    beat.pkt_end    = pend;
    beat.sec_end    = send;
    beat.burst_last = 1'b0;
    expected_words.insert(expected_words.size(), beat);
  endtask

  // four gathered bytes make one word
  task automatic gather_byte(input logic [7:0] value, input logic send);
    logic pend;
    pkt_pos = pkt_pos + 8'd1;
    if (gather_cnt == 2'd3) begin
      pend = (pkt_pos >= psp_pkg::PACKET_BYTES);
      emit_expected_word({gather, value}, pend, send && pend);
      gather     = '0;
      gather_cnt = '0;
      if (pend) pkt_pos = '0;
    end else begin
      gather     = {gather[15:0], value};
      gather_cnt = gather_cnt + 2'd1;
    end
  endtask

  task automatic emit_header(input logic start);
    int          idx;
    logic [3:0]  cc;
    idx = int'(sec_slot) % CC_SLOTS;
    cc  = cont_cnt[idx];
    emit_expected_word({psp_pkg::SYNC_BYTE, 1'b0, start, 1'b0, sec_pid,
                        psp_pkg::ADAPT_PAYLOAD, cc}, 1'b0, 1'b0);
    cont_cnt[idx] = cc + 4'd1;
    gather     = '0;
    gather_cnt = '0;
    pkt_pos    = 8'd4;
  endtask

  task automatic predict_section_byte(input logic [7:0] value, input logic [12:0] pid,
                                      input logic slot);
    int       queue_mark;
    ts_beat_t tail;
    queue_mark = expected_words.size();
    if (!in_sec) begin
      sec_pid  = pid;
      sec_slot = slot;
      in_sec   = 1'b1;
      seen     = '0;
      sec_len  = '0;
      emit_header(1'b1);
      gather_byte(psp_pkg::POINTER_BYTE, 1'b0);
    end else if (pkt_pos == 8'd0) begin
      emit_header(1'b0);
    end

    // length field sits in bytes one and two, top nibble ignored
    if (seen == 13'd1)
      sec_len = {1'b0, value[3:0], 8'h00};
    else if (seen == 13'd2)
      sec_len = 13'd3 + (sec_len | {5'b0, value});
    seen = seen + 13'd1;

    if (seen >= 13'd3 && seen >= sec_len) begin
      if (int'(pkt_pos) + 1 >= int'(psp_pkg::PACKET_BYTES)) begin
        gather_byte(value, 1'b1);
      end else begin
        gather_byte(value, 1'b0);
        while (pkt_pos != 8'd0) gather_byte(psp_pkg::STUFF_BYTE, 1'b1);
      end
      in_sec     = 1'b0;
      seen       = '0;
      pkt_pos    = '0;
      gather     = '0;
      gather_cnt = '0;
    end else begin
      gather_byte(value, 1'b0);
    end

    if (expected_words.size() > queue_mark) begin
      tail = expected_words[expected_words.size() - 1];
      tail.burst_last = 1'b1;
      expected_words[expected_words.size() - 1] = tail;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CC_SLOTS; k++) cont_cnt[k] = '0;
      in_sec        = 1'b0;
      seen          = '0;
      sec_len       = '0;
      pkt_pos       = '0;
      gather        = '0;
      gather_cnt    = '0;
      sec_pid       = '0;
      sec_slot      = 1'b0;
      mismatches    = 0;
      words_checked = 0;
      sections_done = 0;
      expected_words.delete();
      words_pending <= 0;
    end else begin
      if (in_valid && in_ready)
        predict_section_byte(in_section_byte, in_stream_pid, in_counter_slot);
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", out_ts_word, 32'h0);
        end else begin
          head = expected_words.pop_front();
          if (out_ts_word !== head.word)
            report_mismatch("ts_word", out_ts_word, head.word);
          if (out_packet_end !== head.pkt_end)
            report_mismatch("packet_end", 32'(out_packet_end), 32'(head.pkt_end));
          if (out_section_end !== head.sec_end)
            report_mismatch("section_end", 32'(out_section_end), 32'(head.sec_end));
          if (out_last_in_burst !== head.burst_last)
            report_mismatch("last_in_burst", 32'(out_last_in_burst),
                            32'(head.burst_last));
          words_checked++;
          if (head.sec_end) sections_done++;
        end
      end
      words_pending <= expected_words.size();
    end
  end

endmodule

FILE: test/psi_section_to_ts_packetizer_top_test.sv
`timescale 1ns / 1ps
// psi_section_to_ts_packetizer_top_test: drives section bytes with random gaps and
// back-pressure, and gives the verdict from psp_stream_checker
// depends on psi_section_to_ts_packetizer_top, psp_stream_checker and psp_pkg
module psi_section_to_ts_packetizer_top_test;

  localparam int IDLE_LIMIT = 4000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_section_byte;
  logic [12:0] in_stream_pid;
  logic        in_counter_slot;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_ts_word;
  logic        out_packet_end;
  logic        out_section_end;
  logic        out_last_in_burst;

  int mismatches;
  int words_pending;
  int words_checked;
  int sections_done;
  int items_sent;
  int idle_cycles;

  psi_section_to_ts_packetizer_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_section_byte   (in_section_byte),
    .in_stream_pid     (in_stream_pid),
    .in_counter_slot   (in_counter_slot),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_ts_word       (out_ts_word),
    .out_packet_end    (out_packet_end),
    .out_section_end   (out_section_end),
    .out_last_in_burst (out_last_in_burst)
  );

  psp_stream_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_section_byte   (in_section_byte),
    .in_stream_pid     (in_stream_pid),
    .in_counter_slot   (in_counter_slot),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_ts_word       (out_ts_word),
    .out_packet_end    (out_packet_end),
    .out_section_end   (out_section_end),
    .out_last_in_burst (out_last_in_burst),
    .mismatches        (mismatches),
    .words_pending     (words_pending),
    .words_checked     (words_checked),
    .sections_done     (sections_done)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // one whole section; pid and slot only matter on the first byte
  task automatic send_section(input logic [11:0] len_field, input logic [12:0] pid,
                              input logic slot, input logic [7:0] lead,
                              input logic [3:0] spare);
    int         total_bytes;
    int         gap;
    bit         quiet;
    logic [7:0] value;
    total_bytes = int'(len_field) + 3;
    quiet = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < total_bytes; i++) begin
      case (i)
        0: begin
          value = lead;
        end
        1: begin
          value = {spare, len_field[11:8]};
        end
        2: begin
          value = len_field[7:0];
        end
        default: begin
          value = 8'($urandom_range(0, 255));
        end
      endcase
      gap = quiet ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid        <= 1'b1;
      in_section_byte <= value;
      in_stream_pid   <= (i == 0) ? pid : 13'($urandom_range(0, 8191));
      in_counter_slot <= (i == 0) ? slot : 1'($urandom_range(0, 1));
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      items_sent++;
    end
  endtask

  initial begin
    int         sec_idx;
    int         pick;
    logic [11:0] len_field;
    logic       slot;
    in_valid        <= 1'b0;
    in_section_byte <= '0;
    in_stream_pid   <= '0;
    in_counter_slot <= 1'b0;
    items_sent = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // short sections, the first two at the field extremes, with varied spare length bits
    send_section(12'd0, 13'h1fff, 1'b1, 8'hff, 4'hf);
    send_section(12'd0, 13'h0000, 1'b0, 8'h00, 4'h0);
    send_section(12'd2, 13'($urandom_range(0, 8191)), 1'b1, 8'h02, 4'ha);
    send_section(12'd7, 13'($urandom_range(0, 8191)), 1'b0, 8'h80, 4'h5);

    sec_idx = 0;
    while (sec_idx < 17) begin
      pick = $urandom_range(0, 9);
      if (sec_idx == 4)
        len_field = 12'd180;          // last byte fills the first packet exactly
      else if (pick < 8)
        len_field = 12'($urandom_range(0, 3));
      else
        len_field = 12'($urandom_range(4, 10));
      // slot 0 favoured so its counter wraps
      slot = (sec_idx % 8 == 7);
      send_section(len_field, 13'($urandom_range(0, 8191)), slot,
                   8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
      if (sec_idx == 8) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0) @(posedge clk);
      end
      sec_idx++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("summary: %0d section bytes in %0d sections, %0d stream words checked",
             items_sent, sections_done, words_checked);
    $display("covered: short sections, exact packet fill, stuffing to the packet end, "
             , "counter wrap, receiver hold-off and a mid-run drain");
    if (mismatches == 0 && words_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // receiver: random gaps, quiet stretches, and one long hold-off to fill the block
  initial begin
    int gap;
    int beats;
    bit quiet;
    bit held;
    out_ready <= 1'b0;
    beats = 0;
    quiet = 1'b0;
    held  = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (beats % 40 == 0) quiet = ($urandom_range(0, 2) == 0);
      gap = quiet ? 0 : $urandom_range(0, 10);
      if (!held && beats == 50) begin
        gap  = 300;
        held = 1'b1;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      beats++;
    end
  end

  // cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
